@@ rtl/core/cicd_pkg.sv @@
`timescale 1ns / 1ps
package cicd_pkg;

  localparam int MESH_SIZE  = 32;
  localparam int SLAB_DEPTH = 32;

  // index widths; y and z wrap by masking, so MESH_SIZE is a power of two
  localparam int YW    = $clog2(MESH_SIZE);
  localparam int PW    = (SLAB_DEPTH > 1) ? $clog2(SLAB_DEPTH) : 1;
  localparam int AW    = PW + 2 * YW;
  localparam int DEPTH = SLAB_DEPTH * MESH_SIZE * MESH_SIZE;

  localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] REG_CELL_SCALE  = 2'd0;
  localparam logic [1:0] REG_MASS_FACTOR = 2'd1;
  localparam logic [1:0] REG_SLAB_START  = 2'd2;
  localparam logic [1:0] REG_SLAB_WIDTH  = 2'd3;

  typedef logic [AW-1:0] addr_t;

  function automatic logic [11:0] cube4(input logic [3:0] m);
    logic [11:0] mm;
    mm = 12'(m) * 12'(m);
    return mm * 12'(m);
  endfunction

endpackage

@@ rtl/core/cicd_if.sv @@
`timescale 1ns / 1ps
interface cicd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [4:0]         cell_x;
  logic [4:0]         cell_y;
  logic [4:0]         cell_z;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z,
                  input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z,
                output ready);
endinterface

interface cicd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_value;
  modport source (output valid, cell_value, input ready);
  modport sink (input valid, cell_value, output ready);
endinterface

@@ rtl/core/cicd_ram.sv @@
`timescale 1ns / 1ps
module cicd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/core/cicd_mul.sv @@
`timescale 1ns / 1ps
module cicd_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule

@@ rtl/core/cic_density_deposit_top.sv @@
`timescale 1ns / 1ps
// Cloud-in-cell density deposit onto a 32-plane x-slab of a 32x32 mesh of Q16.16 cells,
// held in one single-port-write, registered-read memory and driven by one shared
// registered 34x34 multiplier. After reset, and for every clear command, the block sweeps
// the memory writing -1.0, one cell a cycle, and takes no transaction meanwhile. A deposit
// scales the coordinates in ST_MX to ST_MW, then visits the eight neighbour cells, each
// through ST_C0 to ST_C5 inside the slab (ST_C0 alone for a cell outside it); the multiplier
// and the read-modify-write of each cell set these steps. A read passes ST_RD0 and ST_RD1.
// Every command returns one result, which waits in an output register.
module cic_density_deposit_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  cicd_in_if.sink      in_i,
  cicd_out_if.source   out_o
);
  import cicd_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MX    = 4'd2;
  localparam logic [3:0] ST_MY    = 4'd3;
  localparam logic [3:0] ST_MZ    = 4'd4;
  localparam logic [3:0] ST_MW    = 4'd5;
  localparam logic [3:0] ST_C0    = 4'd6;
  localparam logic [3:0] ST_C1    = 4'd7;
  localparam logic [3:0] ST_C2    = 4'd8;
  localparam logic [3:0] ST_C3    = 4'd9;
  localparam logic [3:0] ST_C4    = 4'd10;
  localparam logic [3:0] ST_C5    = 4'd11;
  localparam logic [3:0] ST_RD0   = 4'd12;
  localparam logic [3:0] ST_RD1   = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  // configuration
  logic [31:0] cell_scale_q;
  logic [11:0] fac_q;
  logic [7:0]  slab_start_q;
  logic [5:0]  slab_width_q;
  logic [8:0]  lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_scale_q <= 32'd65536;
      fac_q        <= 12'd1;
      slab_start_q <= 8'd0;
      slab_width_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_SCALE:  cell_scale_q <= cfg_data_i;
        REG_MASS_FACTOR: fac_q        <= cube4(cfg_data_i[3:0]);
        REG_SLAB_START:  slab_start_q <= cfg_data_i[7:0];
        REG_SLAB_WIDTH:  slab_width_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign lim = (9'(slab_width_q) < 9'(SLAB_DEPTH)) ? 9'(slab_width_q) : 9'(SLAB_DEPTH);

  // sequencer state
  logic [3:0]  state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic        from_cmd_q, from_cmd_d;
  logic [2:0]  cell_q, cell_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  // payload
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [4:0]  rd_x_q, rd_y_q, rd_z_q;
  logic [1:0]  cmd_q;
  logic signed [31:0] cx_q;
  logic [15:0] fx_q, fy_q, fz_q;
  logic [YW-1:0] yi_q, zi_q;
  logic [1:0]  plane_ok_q;
  logic [PW-1:0] plane_q [2];
  logic [32:0] yz_q;
  logic [27:0] fxw_q;
  logic [60:0] acc_q, wsum_q;
  logic [31:0] result_q;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  cicd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // mesh memory
  logic        ram_we;
  addr_t       ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  cicd_ram #(
    .Width (32),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // current neighbour cell
  logic        sel_a, sel_b, sel_c;
  logic [16:0] wx_sel, wy_sel, wz_sel;
  logic [YW-1:0] y_sel, z_sel;
  addr_t       cell_addr;
  logic signed [33:0] px0, px1;
  logic [32:0] sat_sum;
  logic        rd_ok;
  logic        accept;

  assign sel_a  = cell_q[2];
  assign sel_b  = cell_q[1];
  assign sel_c  = cell_q[0];
  assign wx_sel = sel_a ? {1'b0, fx_q} : 17'd65536 - 17'(fx_q);
  assign wy_sel = sel_b ? {1'b0, fy_q} : 17'd65536 - 17'(fy_q);
  assign wz_sel = sel_c ? {1'b0, fz_q} : 17'd65536 - 17'(fz_q);
  assign y_sel  = sel_b ? yi_q + YW'(1) : yi_q;
  assign z_sel  = sel_c ? zi_q + YW'(1) : zi_q;
  assign cell_addr = {plane_q[sel_a], y_sel, z_sel};

  assign px0 = 34'(cx_q) - 34'(slab_start_q);
  assign px1 = px0 + 34'sd1;

  // saturate upwards only: the weight is never negative
  assign sat_sum = 33'($signed(ram_rdata)) + 33'(wsum_q[60:32]);

  assign rd_ok = (9'(rd_x_q) < lim) && (32'(rd_y_q) < 32'(MESH_SIZE))
                 && (32'(rd_z_q) < 32'(MESH_SIZE));

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    from_cmd_d  = from_cmd_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_wdata   = ram_rdata;
    ram_raddr   = cell_addr;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = MINUS_ONE_Q16;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = from_cmd_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_d = '0;
          cnt_d  = '0;
          case (in_i.cmd)
            CMD_CLEAR: begin
              from_cmd_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            CMD_DEPOSIT: state_d = ST_MX;
            CMD_READ:    state_d = ST_RD0;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_MX: begin
        mul_a   = 34'(pos_x_q);
        mul_b   = {2'b00, cell_scale_q};
        state_d = ST_MY;
      end
      ST_MY: begin
        mul_a   = 34'(pos_y_q);
        mul_b   = {2'b00, cell_scale_q};
        state_d = ST_MZ;
      end
      ST_MZ: begin
        mul_a   = 34'(pos_z_q);
        mul_b   = {2'b00, cell_scale_q};
        state_d = ST_MW;
      end
      ST_MW: state_d = ST_C0;
      ST_C0: begin
        if (!plane_ok_q[sel_a]) begin
          cell_d  = cell_q + 3'd1;
          state_d = (cell_q == 3'd7) ? ST_DONE : ST_C0;
        end else begin
          mul_a   = 34'(wy_sel);
          mul_b   = 34'(wz_sel);
          state_d = ST_C1;
        end
      end
      ST_C1: begin
        mul_a   = 34'(fac_q);
        mul_b   = 34'(wx_sel);
        state_d = ST_C2;
      end
      ST_C2: begin
        mul_a   = 34'(mul_p[27:0]);
        mul_b   = 34'(yz_q[16:0]);
        state_d = ST_C3;
      end
      ST_C3: begin
        mul_a   = 34'(fxw_q);
        mul_b   = 34'(yz_q[32:17]);
        state_d = ST_C4;
      end
      ST_C4: state_d = ST_C5;
      ST_C5: begin
        ram_we    = 1'b1;
        ram_wdata = sat_sum[32] ? sat_sum[31:0] :
                    (sat_sum[31] ? 32'h7FFF_FFFF : sat_sum[31:0]);
        cell_d    = cell_q + 3'd1;
        state_d   = (cell_q == 3'd7) ? ST_DONE : ST_C0;
      end
      ST_RD0: begin
        ram_raddr = {PW'(rd_x_q), YW'(rd_y_q), YW'(rd_z_q)};
        state_d   = ST_RD1;
      end
      ST_RD1: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = result_q;
          from_cmd_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      from_cmd_q  <= 1'b0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      from_cmd_q  <= from_cmd_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      cmd_q    <= in_i.cmd;
      pos_x_q  <= in_i.pos_x;
      pos_y_q  <= in_i.pos_y;
      pos_z_q  <= in_i.pos_z;
      rd_x_q   <= in_i.cell_x;
      rd_y_q   <= in_i.cell_y;
      rd_z_q   <= in_i.cell_z;
      result_q <= '0;
    end
    case (state_q)
      ST_MY: begin
        cx_q <= mul_p[63:32];
        fx_q <= mul_p[31:16];
      end
      ST_MZ: begin
        yi_q <= mul_p[32+YW-1:32];
        fy_q <= mul_p[31:16];
        plane_ok_q[0] <= !px0[33] && (px0 < 34'(lim));
        plane_ok_q[1] <= !px1[33] && (px1 < 34'(lim));
        plane_q[0]    <= px0[PW-1:0];
        plane_q[1]    <= px1[PW-1:0];
      end
      ST_MW: begin
        zi_q <= mul_p[32+YW-1:32];
        fz_q <= mul_p[31:16];
      end
      ST_C1: yz_q  <= mul_p[32:0];
      ST_C2: fxw_q <= mul_p[27:0];
      ST_C3: acc_q <= 61'(mul_p[44:0]) + 61'h0_8000_0000;
      ST_C4: wsum_q <= acc_q + {mul_p[43:0], 17'd0};
      ST_RD1: begin
        if (cmd_q == CMD_READ && rd_ok) begin
          result_q <= ram_rdata;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_value = out_data_q;

endmodule

@@ rtl/core/cicd_chk.sv @@
`timescale 1ns / 1ps
module cicd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i
);
  // the clearing pass after reset holds the input off
  a_busy_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_i)
    else $error("input ready during reset clearing pass");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted transaction");

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before it was taken");
endmodule

bind cic_density_deposit_top cicd_chk u_cicd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

@@ verif/density_mirror.sv @@
`timescale 1ns / 1ps
module density_mirror (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  cicd_in_if          in_m,
  cicd_out_if         out_m,
  output int          fail_count,
  output int          pending
);
  import cicd_pkg::*;

  logic signed [31:0] density [DEPTH];
  logic [31:0]        scale_q;
  logic [3:0]         mass_q;
  logic [7:0]         start_q;
  logic [5:0]         width_q;
  logic signed [31:0] cell_values_due [$];

  function automatic int planes_used();
    return (int'(width_q) < SLAB_DEPTH) ? int'(width_q) : SLAB_DEPTH;
  endfunction

  task automatic clear_density();
    foreach (density[i]) density[i] = MINUS_ONE_Q16;
  endtask

  // Q32.32 product; index is the upper word (floor), fraction the 16 bits below the point
  task automatic scale_coord(input logic signed [31:0] pos, output longint cell_idx,
                             output logic [16:0] frac);
    longint prod;
    prod = longint'(pos) * longint'({32'b0, scale_q});
    cell_idx = longint'($signed(prod[63:32]));
    frac = {1'b0, prod[31:16]};
  endtask

  task automatic deposit_particle(input logic signed [31:0] px, py, pz);
    longint      cx, cy, cz, plane, sum;
    logic [16:0] fx, fy, fz;
    logic [16:0] wx [2];
    logic [16:0] wy [2];
    logic [16:0] wz [2];
    logic [4:0]  yi [2];
    logic [4:0]  zi [2];
    logic [11:0] fac;
    logic [63:0] w;
    int          idx;
    scale_coord(px, cx, fx);
    scale_coord(py, cy, fy);
    scale_coord(pz, cz, fz);
    fac = 12'(mass_q) * 12'(mass_q) * 12'(mass_q);
    wx[1] = fx; wx[0] = 17'd65536 - fx;
    wy[1] = fy; wy[0] = 17'd65536 - fy;
    wz[1] = fz; wz[0] = 17'd65536 - fz;
    // periodic in y and z: low bits of the floored index
    yi[0] = cy[4:0]; yi[1] = yi[0] + 5'd1;
    zi[0] = cz[4:0]; zi[1] = zi[0] + 5'd1;
    for (int a = 0; a < 2; a++) begin
      plane = cx + a - longint'(start_q);
      if (plane < 0 || plane >= planes_used()) continue;
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < 2; c++) begin
          w = 64'(fac) * 64'(wx[a]) * 64'(wy[b]) * 64'(wz[c]);
          w = (w + 64'h8000_0000) >> 32;
          idx = (int'(plane) * MESH_SIZE + int'(yi[b])) * MESH_SIZE + int'(zi[c]);
          sum = longint'(density[idx]) + longint'(w);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          density[idx] = sum[31:0];
        end
      end
    end
  endtask

  function automatic logic signed [31:0] read_density(input logic [4:0] x, y, z);
    if (int'(x) >= planes_used()) return 32'sd0;
    return density[(int'(x) * MESH_SIZE + int'(y)) * MESH_SIZE + int'(z)];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] due;
    if (!rst_ni) begin
      scale_q = 32'h0001_0000;
      mass_q  = 4'd1;
      start_q = 8'd0;
      width_q = 6'd32;
      clear_density();
      cell_values_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CELL_SCALE:  scale_q = cfg_data_i;
          REG_MASS_FACTOR: mass_q  = cfg_data_i[3:0];
          REG_SLAB_START:  start_q = cfg_data_i[7:0];
          REG_SLAB_WIDTH:  width_q = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        if (cell_values_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   out_m.cell_value);
          fail_count++;
        end else begin
          due = cell_values_due.pop_front();
          if (out_m.cell_value !== due) begin
            $display("%0t: cell_value mismatch, expected %h, actual %h", $time, due,
                     out_m.cell_value);
            fail_count++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        due = 32'sd0;
        case (in_m.cmd)
          CMD_CLEAR:   clear_density();
          CMD_DEPOSIT: deposit_particle(in_m.pos_x, in_m.pos_y, in_m.pos_z);
          CMD_READ:    due = read_density(in_m.cell_x, in_m.cell_y, in_m.cell_z);
          default: ;
        endcase
        cell_values_due.push_back(due);
      end
    end
    pending = cell_values_due.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import cicd_pkg::*;

  localparam logic [1:0] CMD_IDLE = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 60;

  typedef struct {
    logic [31:0] scale;
    logic [3:0]  mass;
    logic [7:0]  start;
    logic [5:0]  width;
    int          lo;
    int          hi;
    int          n;
  } phase_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          tx_idle;
  int          rx_idle;
  int          hold_cycles;
  int          sent;
  longint      cycles;
  phase_t      phases [7];

  cicd_in_if  in_c ();
  cicd_out_if out_c ();

  cic_density_deposit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_c),
    .out_o      (out_c)
  );

  density_mirror u_mirror (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_m       (in_c),
    .out_m      (out_c),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cic_density_deposit_top test failed");
      $finish;
    end
  end

  // receiver: a long hold-off when asked, random back-pressure otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_c.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_c.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // drop the offer, then wait until every result is back
  task automatic drain();
    in_c.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] px, py, pz,
                           input logic [4:0] cx, cy, cz);
    sent++;
    if (sent < 633) begin
      tx_idle = 9; rx_idle = 84;
    end else if (sent < 1266) begin
      tx_idle = 84; rx_idle = 9;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
    while ($urandom_range(99) < tx_idle) begin
      in_c.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_c.valid  <= 1'b1;
    in_c.cmd    <= cmd;
    in_c.pos_x  <= px;
    in_c.pos_y  <= py;
    in_c.pos_z  <= pz;
    in_c.cell_x <= cx;
    in_c.cell_y <= cy;
    in_c.cell_z <= cz;
    do @(posedge clk_i); while (!in_c.ready);
  endtask

  function automatic logic [31:0] pick_pos(input int lo, hi);
    if ($urandom_range(9) == 0) return $urandom;
    return 32'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // reads mostly land near the low corner, where deposits gather
  function automatic logic [4:0] pick_cell();
    if ($urandom_range(9) < 6) return 5'($urandom_range(7) - 2);
    return 5'($urandom);
  endfunction

  task automatic random_item(input phase_t ph);
    logic [1:0] cmd;
    int         r;
    r = $urandom_range(99);
    if (r < 55) cmd = CMD_DEPOSIT;
    else if (r < 93) cmd = CMD_READ;
    else if (r == 99 && $urandom_range(9) == 0) cmd = CMD_CLEAR;
    else if (r < 96) cmd = CMD_IDLE;
    else cmd = CMD_READ;
    send_item(cmd, pick_pos(ph.lo, ph.hi), pick_pos(ph.lo, ph.hi), pick_pos(ph.lo, ph.hi),
              5'($urandom_range(7)), pick_cell(), pick_cell());
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    tx_idle = 9;
    rx_idle = 84;
    hold_cycles = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_CELL_SCALE;
    cfg_data = '0;
    in_c.valid = 1'b0;
    in_c.cmd = CMD_IDLE;
    in_c.pos_x = '0;
    in_c.pos_y = '0;
    in_c.pos_z = '0;
    in_c.cell_x = '0;
    in_c.cell_y = '0;
    in_c.cell_z = '0;
    out_c.ready = 1'b0;

    phases[0] = '{32'h0001_0000, 4'd1, 8'd0, 6'd32, -2 << 16, 6 << 16, 300};
    phases[1] = '{32'h0020_0000, 4'd8, 8'd0, 6'd32, -32'h1000, 32'h3000, 300};
    phases[2] = '{32'h0001_0000, 4'd3, 8'd5, 6'd1, 2 << 16, 9 << 16, 250};
    phases[3] = '{32'hFFFF_FFFF, 4'd1, 8'd255, 6'd32, -8, 300, 250};
    phases[4] = '{32'h0000_0000, 4'd15, 8'd0, 6'd63, -2 << 16, 6 << 16, 200};
    phases[5] = '{32'h0001_0000, 4'd0, 8'd0, 6'd0, -2 << 16, 6 << 16, 150};
    phases[6] = '{32'h0001_8000, 4'd2, 8'd3, 6'd17, -1 << 16, 14 << 16, 450};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, wrap-around, floor of negatives, extremes, unused command, clear
    send_item(CMD_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
    send_item(CMD_DEPOSIT, 32'h001F_8000, 32'h001F_8000, 32'h001F_8000, 0, 0, 0);
    send_item(CMD_DEPOSIT, 32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_C000, 0, 0, 0);
    send_item(CMD_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(CMD_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_item(CMD_DEPOSIT, 32'h0000_4000, 32'h0001_C000, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(CMD_READ, '0, '0, '0, 0, 0, 0);
    send_item(CMD_READ, '0, '0, '0, 0, 31, 31);
    send_item(CMD_READ, '0, '0, '0, 0, 0, 31);
    send_item(CMD_READ, '0, '0, '0, 31, 31, 31);
    send_item(CMD_READ, '0, '0, '0, 31, 0, 0);
    send_item(CMD_READ, '0, '0, '0, 0, 1, 0);
    send_item(CMD_IDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 31, 31);
    send_item(CMD_READ, '0, '0, '0, 0, 0, 0);
    send_item(CMD_CLEAR, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    send_item(CMD_READ, '0, '0, '0, 0, 0, 0);
    send_item(CMD_READ, '0, '0, '0, 31, 31, 31);

    foreach (phases[p]) begin
      drain();
      write_reg(REG_CELL_SCALE, phases[p].scale);
      write_reg(REG_MASS_FACTOR, 32'(phases[p].mass));
      write_reg(REG_SLAB_START, 32'(phases[p].start));
      write_reg(REG_SLAB_WIDTH, 32'(phases[p].width));
      // hold the output off while items keep coming, so the input stalls
      if (p == 1) hold_cycles = 400;
      repeat (phases[p].n) random_item(phases[p]);
    end

    drain();
    if (fail_count == 0) begin
      $display("cic_density_deposit_top test passed");
    end else begin
      $display("cic_density_deposit_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cicd_pkg.sv
rtl/core/cicd_if.sv
rtl/core/cicd_ram.sv
rtl/core/cicd_mul.sv
rtl/core/cic_density_deposit_top.sv
rtl/core/cicd_chk.sv
verif/density_mirror.sv
verif/testbench.sv
